FILE: src/ablc_pkg.sv
// package for the adaptive burst limit controller
// holds widths and fixed thresholds; no dependencies
package ablc_pkg;

  localparam int unsigned LimitW = 10;
  localparam int unsigned CountW = 16;
  localparam int unsigned DrainW = 2;
  localparam int unsigned QuietW = 5;
  localparam int unsigned CalcW  = LimitW + 2;

  localparam logic [LimitW-1:0] MaxLimit       = 10'd1000;
  localparam logic [LimitW-1:0] FloorReset     = 10'd100;
  localparam logic [CountW:0]   GrowThreshold  = 17'd50;
  localparam logic [CountW:0]   DrainThreshold = 17'd30;
  localparam logic [CountW-1:0] QuietOccupancy = 16'd50;
  localparam logic [CalcW-1:0]  GrowStep       = 12'd30;
  localparam logic [CalcW-1:0]  DecayStep      = 12'd10;
  localparam logic [DrainW-1:0] DrainPeriod    = 2'd2;
  localparam logic [QuietW-1:0] QuietPeriod    = 5'd30;

  typedef logic [LimitW-1:0] limit_t;
  typedef logic [CountW-1:0] count_t;

endpackage

FILE: src/adaptive_burst_limit_control.sv
// top level of the adaptive burst limit controller
// uses ablc_pkg; checker ablc_checker binds to it
//
// One sample enters per cycle while in_ready_o is high. Its new limit passes
// through an input register, the update logic, then a result register, from
// which the output side takes it under the valid/ready handshake.
// Sustained rate is one sample per clock while the output side takes results.
// The previous occupancy and the drain and quiet counters are updated as each
// sample moves into the result register, so consecutive samples chain
// correctly at full rate. The floor register is written through the
// configuration channel, which is always ready, and resets to 100.
module adaptive_burst_limit_control (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  ablc_pkg::limit_t       floor_limit_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  ablc_pkg::limit_t       current_limit_i,
  input  logic                   suspended_i,
  input  ablc_pkg::count_t       queue_count_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output ablc_pkg::limit_t       new_limit_o
);

  ablc_pkg::limit_t floor_q;
  logic             in_valid_q;
  ablc_pkg::limit_t lim_q;
  logic             susp_q;
  ablc_pkg::count_t cur_q;
  logic             out_valid_q;
  ablc_pkg::limit_t out_limit_q, out_limit_d;

  ablc_pkg::count_t                   prev_q;
  logic [ablc_pkg::DrainW-1:0]        drain_q, drain_d;
  logic [ablc_pkg::QuietW-1:0]        quiet_q, quiet_d;

  ablc_pkg::count_t                   prev_eff;
  logic                               grow, drain;
  logic signed [ablc_pkg::CalcW-1:0]  lim_s, adj_s, floor_s, clamp_s;
  logic                               advance;

  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign new_limit_o = out_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= ablc_pkg::FloorReset;
    end else if (cfg_valid_i) begin
      floor_q <= floor_limit_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      lim_q  <= current_limit_i;
      susp_q <= suspended_i;
      cur_q  <= queue_count_i;
    end
  end

  // update logic
  always_comb begin
    prev_eff = (prev_q == '0) ? cur_q : prev_q;
    grow     = {1'b0, cur_q} > ({1'b0, prev_eff} + ablc_pkg::GrowThreshold);
    drain    = {1'b0, prev_eff} > ({1'b0, cur_q} + ablc_pkg::DrainThreshold);
    lim_s    = $signed({2'b00, lim_q});
    floor_s  = $signed({2'b00, floor_q});
    adj_s    = lim_s;
    drain_d  = drain_q;
    quiet_d  = quiet_q;
    if (susp_q) begin
      adj_s = lim_s - $signed(ablc_pkg::DecayStep);
    end else if (grow) begin
      adj_s = lim_s + $signed(ablc_pkg::GrowStep);
    end else if (drain) begin
      if (drain_q < ablc_pkg::DrainPeriod) begin
        drain_d = drain_q + {{(ablc_pkg::DrainW-1){1'b0}}, 1'b1};
      end else begin
        adj_s   = lim_s - $signed(ablc_pkg::DecayStep);
        drain_d = '0;
      end
    end else begin
      if (quiet_q < ablc_pkg::QuietPeriod) begin
        quiet_d = quiet_q + {{(ablc_pkg::QuietW-1){1'b0}}, 1'b1};
      end else if (lim_q > floor_q && cur_q < ablc_pkg::QuietOccupancy) begin
        adj_s   = lim_s - $signed(ablc_pkg::DecayStep);
        quiet_d = '0;
      end
    end
    clamp_s     = (adj_s < floor_s) ? floor_s : adj_s;
    out_limit_d = (clamp_s > $signed({2'b00, ablc_pkg::MaxLimit})) ? ablc_pkg::MaxLimit
                                                                 : clamp_s[ablc_pkg::LimitW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      drain_q <= '0;
      quiet_q <= '0;
    end else if (in_valid_q && advance) begin
      prev_q  <= cur_q;
      drain_q <= drain_d;
      quiet_q <= quiet_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && advance) begin
      out_limit_q <= out_limit_d;
    end
  end

endmodule

FILE: src/ablc_checker.sv
// port-level checker for the adaptive burst limit controller
// uses ablc_pkg; bound to adaptive_burst_limit_control below
module ablc_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input ablc_pkg::limit_t new_limit_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(new_limit_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> new_limit_o <= ablc_pkg::MaxLimit)
    else $error("result above max limit");

  // a new result comes from an input transfer that passed through the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without matching input transfer");

  // no input stall while the output side takes results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled with output ready");

endmodule

bind adaptive_burst_limit_control ablc_checker u_ablc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .new_limit_o (new_limit_o)
);
